// ----- rtl/iir3_pkg.sv -----
// Shared types, widths and constants of the multichannel third-order IIR filter.
`default_nettype none

package iir3_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_W   = 32;   // signed Q16.16
  localparam int COEF_W     = 32;   // signed Q3.28
  localparam int COEF_FRAC  = 28;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 3;   // seven products plus rounding, no overflow
  localparam int CHAN_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CHANNELS_DEF = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_B3 = 3'd3,
    REG_A1 = 3'd4,
    REG_A2 = 3'd5,
    REG_A3 = 3'd6
  } cfg_reg_t;

  // Coefficient reset values
  localparam coef_t B0_RST = 32'sd420641;
  localparam coef_t B1_RST = 32'sd1261923;
  localparam coef_t B2_RST = 32'sd1261923;
  localparam coef_t B3_RST = 32'sd420641;
  localparam coef_t A1_RST = -32'sd670715072;
  localparam coef_t A2_RST = 32'sd567809217;
  localparam coef_t A3_RST = -32'sd162164465;

  // Full coefficient set handed to the datapath
  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t b3;
    coef_t a1;
    coef_t a2;
    coef_t a3;
  } coef_set_t;

  // Per-channel history: last three inputs and last three outputs
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t x3;
    sample_t y1;
    sample_t y2;
    sample_t y3;
  } hist_t;

endpackage

`default_nettype wire

// ----- rtl/iir3_in_if.sv -----
// Input channel interface: one sample and its channel number per transfer.
`default_nettype none

interface iir3_in_if
  import iir3_pkg::*;
();
  logic              valid;
  logic              ready;
  sample_t           sample_in;
  logic [CHAN_W-1:0] channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

`default_nettype wire

// ----- rtl/iir3_out_if.sv -----
// Result channel interface: filtered sample, channel echo and clip flag per transfer.
`default_nettype none

interface iir3_out_if
  import iir3_pkg::*;
();
  logic              valid;
  logic              ready;
  sample_t           sample_out;
  logic [CHAN_W-1:0] channel_out;
  logic              saturated;

  modport source (output valid, output sample_out, output channel_out, output saturated,
                  input ready);
  modport sink   (input valid, input sample_out, input channel_out, input saturated,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/iir3_datapath.sv -----
// Filter arithmetic: seven products, exact sum, round half up and saturation.
`default_nettype none

module iir3_datapath
  import iir3_pkg::*;
(
  input  coef_set_t coefs,
  input  sample_t   x,
  input  hist_t     hist,
  output sample_t   y,
  output logic      sat
);

  localparam int R_W = ACC_W - COEF_FRAC;
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEF_FRAC - 1);
  localparam sample_t Y_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t Y_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_b3, p_a1, p_a2, p_a3;
  logic signed [ACC_W-1:0]  acc;
  logic signed [R_W-1:0]    r;

  // Exact Q19.44 products
  assign p_b0 = coefs.b0 * x;
  assign p_b1 = coefs.b1 * hist.x1;
  assign p_b2 = coefs.b2 * hist.x2;
  assign p_b3 = coefs.b3 * hist.x3;
  assign p_a1 = coefs.a1 * hist.y1;
  assign p_a2 = coefs.a2 * hist.y2;
  assign p_a3 = coefs.a3 * hist.y3;

  // Feedforward minus feedback, plus half an output LSB for rounding
  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) + ACC_W'(p_b3)
             - ACC_W'(p_a1) - ACC_W'(p_a2) - ACC_W'(p_a3) + ROUND_C;

  // Floor shift back to Q16.16
  assign r = acc[ACC_W-1:COEF_FRAC];

  // Clip when the upper bits are not a plain sign extension
  always_comb begin
    sat = (r[R_W-1:SAMPLE_W-1] != {(R_W-SAMPLE_W+1){r[SAMPLE_W-1]}});
    if (!sat) begin
      y = r[SAMPLE_W-1:0];
    end else if (r[R_W-1]) begin
      y = Y_MIN;
    end else begin
      y = Y_MAX;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/iir_third_order_multichannel.sv -----
// Top level of the multichannel third-order direct form I IIR filter.
`default_nettype none

// Accepts one sample per clock cycle while the result side is not stalled, from
// any mix of channels, including the same channel on consecutive cycles. The
// transfer edge loads the filter stage together with a registered read of the
// channel history from the history memory, forwarding the history that an item
// of the same channel writes at that edge. The output register takes the result
// when the filter stage advances, which a stalled result holds off. The filter
// stage is one combinational pass of seven 32x32 products, a 67-bit sum,
// rounding and clipping, and that pass sets the clock rate. The output register
// decouples the sides, so a stalled result still lets one more item enter.
// History is held in a CHANNELS-deep memory with one valid bit per channel
// that reset clears at once; there is no clearing pass. Channels at or above
// CHANNELS filter with an all-zero history and leave no history behind. The
// user writes coefficients through cfg_we/cfg_index/cfg_wdata only while the
// filter is idle, unchecked by the block; indexes past the seven are ignored.
module iir_third_order_multichannel
  import iir3_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  iir3_in_if.sink                   in_ch,
  iir3_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_wdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;
  localparam int CMP_W = EXT_W + 1;

  // Coefficient registers
  coef_set_t coefs_r;

  // Filter stage
  logic              s1_v_r;
  sample_t           s1_x_r;
  logic [CHAN_W-1:0] s1_ch_r;
  logic              s1_ok_r;
  logic              s1_byp_r;
  logic              s1_vld_r;
  hist_t             s1_byp_hist_r;
  hist_t             s1_mem_hist_r;
  hist_t             s1_hist;
  hist_t             hist_new;
  sample_t           y;
  logic              sat;

  // Output register
  logic              out_v_r;
  sample_t           out_sample_r;
  logic [CHAN_W-1:0] out_ch_r;
  logic              out_sat_r;

  // History store
  hist_t             hist_mem [CHANNELS];
  logic [CHANNELS-1:0] hist_vld_r;

  logic [EXT_W-1:0]  in_ext, s1_ext;
  logic [IDX_W-1:0]  in_idx, s1_idx;
  logic              in_ok;
  logic              in_xfer, s1_adv, commit;

  // Channel number to memory index and range check
  assign in_ext = EXT_W'(in_ch.channel);
  assign s1_ext = EXT_W'(s1_ch_r);
  assign in_idx = in_ext[IDX_W-1:0];
  assign s1_idx = s1_ext[IDX_W-1:0];
  assign in_ok  = ({1'b0, in_ext} < CMP_W'(CHANNELS));

  // Handshake
  assign s1_adv       = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign commit       = s1_adv && s1_ok_r;

  // Coefficient writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r <= '{b0: B0_RST, b1: B1_RST, b2: B2_RST, b3: B3_RST,
                   a1: A1_RST, a2: A2_RST, a3: A3_RST};
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_B0:  coefs_r.b0 <= cfg_wdata;
        REG_B1:  coefs_r.b1 <= cfg_wdata;
        REG_B2:  coefs_r.b2 <= cfg_wdata;
        REG_B3:  coefs_r.b3 <= cfg_wdata;
        REG_A1:  coefs_r.a1 <= cfg_wdata;
        REG_A2:  coefs_r.a2 <= cfg_wdata;
        REG_A3:  coefs_r.a3 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // History of the item in the filter stage: forwarded, stored, or zero
  always_comb begin
    if (!s1_ok_r) begin
      s1_hist = '0;
    end else if (s1_byp_r) begin
      s1_hist = s1_byp_hist_r;
    end else if (s1_vld_r) begin
      s1_hist = s1_mem_hist_r;
    end else begin
      s1_hist = '0;
    end
  end

  iir3_datapath u_datapath (
    .coefs (coefs_r),
    .x     (s1_x_r),
    .hist  (s1_hist),
    .y     (y),
    .sat   (sat)
  );

  // Shifted history written back by this item
  assign hist_new = '{x1: s1_x_r, x2: s1_hist.x1, x3: s1_hist.x2,
                      y1: y,      y2: s1_hist.y1, y3: s1_hist.y2};

  // History memory: write on commit, registered read on input transfer
  always_ff @(posedge clk) begin
    if (commit) begin
      hist_mem[s1_idx] <= hist_new;
    end
    if (in_xfer) begin
      s1_mem_hist_r <= hist_mem[in_idx];
    end
  end

  // Per-channel valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (commit) begin
      hist_vld_r[s1_idx] <= 1'b1;
    end
  end

  // Filter stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  // Filter stage payload, with forwarding from a same-channel commit
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r        <= in_ch.sample_in;
      s1_ch_r       <= in_ch.channel;
      s1_ok_r       <= in_ok;
      s1_vld_r      <= hist_vld_r[in_idx];
      s1_byp_r      <= commit && (s1_idx == in_idx);
      s1_byp_hist_r <= hist_new;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= s1_v_r;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= y;
      out_ch_r     <= s1_ch_r;
      out_sat_r    <= sat;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.sample_out  = out_sample_r;
  assign out_ch.channel_out = out_ch_r;
  assign out_ch.saturated   = out_sat_r;

endmodule

`default_nettype wire

// ----- dv/iir_third_order_multichannel_test.sv -----
// Self-checking testbench for the multichannel third-order direct form I IIR filter.
`timescale 1ns / 100ps

module iir_third_order_multichannel_test;
  import iir3_pkg::*;

  localparam int N_CHAN       = CHANNELS_DEF;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int SUM_W        = 72;

  // Register index past the coefficient map, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 72'sh7FFFFFFF;
  localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -72'sh80000000;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = 72'sd1 <<< (COEF_FRAC - 1);

  localparam coef_set_t RESET_COEFS = '{
    b0: B0_RST, b1: B1_RST, b2: B2_RST, b3: B3_RST, a1: A1_RST, a2: A2_RST, a3: A3_RST
  };

  typedef struct packed {
    sample_t           sample;
    logic [CHAN_W-1:0] chan;
  } filter_in_t;

  typedef struct packed {
    sample_t           sample;
    logic [CHAN_W-1:0] chan;
    logic              clip;
  } filter_out_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_wdata;

  iir3_in_if  in_ch ();
  iir3_out_if out_ch ();

  iir_third_order_multichannel #(
    .CHANNELS (N_CHAN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: coefficient copy and per-channel delay lines
  coef_set_t   coefs;
  hist_t       chan_hist [N_CHAN];

  filter_in_t  sample_queue [$];
  filter_out_t awaited_results [$];

  filter_in_t  head_item;
  filter_in_t  seen_in;
  filter_out_t want;
  filter_out_t got;

  bit idling_on = 1'b1;
  int feed_gap;
  int sink_stall;
  int mismatch_count = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  // Direct form I step: exact sum, round half up, clip, shift the delay lines
  function automatic filter_out_t filter_step(input filter_in_t item);
    filter_out_t             res;
    hist_t                   h;
    logic                    in_range;
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] rnd;
    in_range = item.chan < N_CHAN;
    h = in_range ? chan_hist[item.chan] : '0;
    acc = $signed(item.sample) * $signed(coefs.b0)
        + $signed(h.x1) * $signed(coefs.b1)
        + $signed(h.x2) * $signed(coefs.b2)
        + $signed(h.x3) * $signed(coefs.b3)
        - $signed(h.y1) * $signed(coefs.a1)
        - $signed(h.y2) * $signed(coefs.a2)
        - $signed(h.y3) * $signed(coefs.a3);
    rnd = (acc + ROUND_HALF) >>> COEF_FRAC;
    res.chan = item.chan;
    res.clip = 1'b1;
    if (rnd > SAMPLE_MAX) begin
      res.sample = SAMPLE_MAX[SAMPLE_W-1:0];
    end else if (rnd < SAMPLE_MIN) begin
      res.sample = SAMPLE_MIN[SAMPLE_W-1:0];
    end else begin
      res.sample = rnd[SAMPLE_W-1:0];
      res.clip   = 1'b0;
    end
    // the clipped value is what goes back into the output history
    if (in_range) begin
      chan_hist[item.chan] = '{x1: item.sample, x2: h.x1, x3: h.x2,
                               y1: res.sample,  y2: h.y1, y3: h.y2};
    end
    return res;
  endfunction

  // Full-range extremes now and then, otherwise full-range or small samples
  function automatic sample_t pick_sample(input bit wide);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return SAMPLE_MAX[SAMPLE_W-1:0];
    if (roll == 1) return SAMPLE_MIN[SAMPLE_W-1:0];
    if (wide || roll < 4) return $urandom;
    return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic coef_set_t rand_coefs();
    coef_set_t s;
    s = '{b0: $urandom, b1: $urandom, b2: $urandom, b3: $urandom,
          a1: $urandom, a2: $urandom, a3: $urandom};
    return s;
  endfunction

  task automatic queue_sample(input sample_t s, input logic [CHAN_W-1:0] c);
    filter_in_t item;
    item.sample = s;
    item.chan   = c;
    sample_queue.push_back(item);
  endtask

  // Random stream; a third of the items keep the previous channel without a new draw
  task automatic queue_random(input int count, input bit wide);
    logic [CHAN_W-1:0] ch;
    ch = CHAN_W'($urandom);
    @(negedge clk);
    repeat (count) begin
      if ($urandom_range(0, 2) != 0) ch = CHAN_W'($urandom);
      queue_sample(pick_sample(wide), ch);
    end
  endtask

  // Idle: nothing pending, nothing on the input, every result collected
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_ch.valid || awaited_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic load_coefs(input coef_set_t s);
    write_reg(REG_B0, s.b0);
    write_reg(REG_B1, s.b1);
    write_reg(REG_B2, s.b2);
    write_reg(REG_B3, s.b3);
    write_reg(REG_A1, s.a1);
    write_reg(REG_A2, s.a2);
    write_reg(REG_A3, s.a3);
    write_reg(CFG_IDX_SPARE, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver: holds an item until its transfer, random gaps between items while idling_on
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      feed_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (feed_gap > 0) begin
        feed_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        head_item = sample_queue.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= head_item.sample;
        in_ch.channel   <= head_item.chan;
        if (idling_on && $urandom_range(0, 5) == 0) feed_gap = $urandom_range(1, 4);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in short bursts while idling_on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 6) == 0) begin
      sink_stall = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: tracks register writes, predicts on each input transfer,
  // checks each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      coefs = RESET_COEFS;
      foreach (chan_hist[i]) chan_hist[i] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_B0:  coefs.b0 = cfg_wdata;
          REG_B1:  coefs.b1 = cfg_wdata;
          REG_B2:  coefs.b2 = cfg_wdata;
          REG_B3:  coefs.b3 = cfg_wdata;
          REG_A1:  coefs.a1 = cfg_wdata;
          REG_A2:  coefs.a2 = cfg_wdata;
          REG_A3:  coefs.a3 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_in.sample = in_ch.sample_in;
        seen_in.chan   = in_ch.channel;
        awaited_results.push_back(filter_step(seen_in));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.sample = out_ch.sample_out;
        got.chan   = out_ch.channel_out;
        got.clip   = out_ch.saturated;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: sample %h channel %0d clip %b",
                     got.sample, got.chan, got.clip);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected sample %h channel %0d clip %b, got %h %0d %b",
                       want.sample, want.chan, want.clip, got.sample, got.chan, got.clip);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.channel   = '0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset coefficients: field extremes, every channel, same channel back to back
    @(negedge clk);
    queue_sample(SAMPLE_MAX[SAMPLE_W-1:0], 3'd0);
    queue_sample(SAMPLE_MIN[SAMPLE_W-1:0], 3'd1);
    queue_sample(32'sd0, 3'd2);
    queue_sample(-32'sd1, 3'd3);
    queue_sample(32'sd1, 3'd4);
    repeat (4) queue_sample(SAMPLE_MAX[SAMPLE_W-1:0], 3'd5);
    repeat (4) queue_sample(SAMPLE_MIN[SAMPLE_W-1:0], 3'd6);
    queue_sample(32'sh5555_5555, 3'd7);
    queue_sample(32'shAAAA_AAAA, 3'd7);
    repeat (3) queue_sample(SAMPLE_MAX[SAMPLE_W-1:0], 3'd0);
    wait_idle();

    // Huge current-input gain: clipping both ways, rounding of small negatives
    load_coefs('{b0: 32'h7FFF_FFFF, default: '0});
    @(negedge clk);
    queue_sample(SAMPLE_MAX[SAMPLE_W-1:0], 3'd2);
    queue_sample(SAMPLE_MIN[SAMPLE_W-1:0], 3'd2);
    queue_sample(32'sh0000_0100, 3'd4);
    queue_sample(-32'sd1, 3'd6);
    wait_idle();

    // Random phases over several coefficient settings, extremes included
    load_coefs(RESET_COEFS);
    queue_random(90, 1'b0);
    wait_idle();

    load_coefs('{default: 32'h7FFF_FFFF});
    queue_random(60, 1'b1);
    wait_idle();

    load_coefs('{default: 32'h8000_0000});
    queue_random(60, 1'b1);
    wait_idle();

    // Pass-through: unity current-input gain, no other taps
    load_coefs('{b0: 32'sd1 <<< COEF_FRAC, default: '0});
    queue_random(70, 1'b1);
    wait_idle();

    load_coefs(rand_coefs());
    queue_random(70, 1'b1);
    wait_idle();

    // Final stretch at full rate
    idling_on = 1'b0;
    load_coefs(RESET_COEFS);
    queue_random(90, 1'b0);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
